@@ hw/rtl/servo_status_packet_parser_assert.svh @@
// Assertion macros for the servo status packet parser.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef SERVO_STATUS_PACKET_PARSER_ASSERT_SVH
`define SERVO_STATUS_PACKET_PARSER_ASSERT_SVH

// Implication in the same cycle.
`define SSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("servo status parser: same-cycle check failed");

// Implication in the next cycle.
`define SSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("servo status parser: next-cycle check failed");

`endif

@@ hw/rtl/ssp_pkg.sv @@
// Shared types and constants of the servo status packet parser.
// Used by ssp_cfg_regs, ssp_frame and servo_status_packet_parser.
`default_nettype none

package ssp_pkg;

  localparam int unsigned MaxParamBytes = 2;
  localparam int unsigned ParamIdxW     = 2;
  localparam int unsigned HuntLimit     = 10;

  localparam logic [7:0] HeaderByte    = 8'hFF;
  localparam logic [7:0] BroadcastId   = 8'hFE;
  localparam logic [7:0] StatusOnlyLen = 8'd2;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned ValueW   = 17;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EXPECTED_ID = 3'd0,
    REG_PARAM_LEN   = 3'd1,
    REG_BYTE_ORDER  = 3'd2,
    REG_SIGN_MODE   = 3'd3,
    REG_TIMEOUT_MS  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    SIGN_RAW    = 2'd0,
    SIGN_BIT15  = 2'd1,
    SIGN_BIT10  = 2'd2,
    SIGN_UNUSED = 2'd3
  } sign_mode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_HEADER   = 3'd1,
    ST_TIMEOUT     = 3'd2,
    ST_ID_MISMATCH = 3'd3,
    ST_BAD_LENGTH  = 3'd4,
    ST_CHECKSUM    = 3'd5
  } status_e;

  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_ID    = 6'b000010,
    PH_LEN   = 6'b000100,
    PH_ERR   = 6'b001000,
    PH_PARAM = 6'b010000,
    PH_SUM   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] expected_id;
    logic [1:0] param_len;
    logic       byte_order;
    logic [1:0] sign_mode;
    logic [9:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [7:0]               src_id;
    logic [7:0]               error_byte;
    logic signed [ValueW-1:0] value;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/ssp_cfg_regs.sv @@
// Configuration registers of the servo status packet parser.
// Depends on ssp_pkg for register indexes and the cfg_t struct.
`default_nettype none

module ssp_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ssp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ssp_pkg::CfgDataW-1:0] cfg_wdata_i,
  output ssp_pkg::cfg_t                     cfg_o
);

  ssp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssp_pkg::REG_EXPECTED_ID: cfg_d.expected_id = cfg_wdata_i[7:0];
        ssp_pkg::REG_PARAM_LEN:   cfg_d.param_len   = cfg_wdata_i[1:0];
        ssp_pkg::REG_BYTE_ORDER:  cfg_d.byte_order  = cfg_wdata_i[0];
        ssp_pkg::REG_SIGN_MODE:   cfg_d.sign_mode   = cfg_wdata_i[1:0];
        ssp_pkg::REG_TIMEOUT_MS:  cfg_d.timeout_ms  = cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_id <= 8'd1;
      cfg_q.param_len   <= 2'd2;
      cfg_q.byte_order  <= 1'b0;
      cfg_q.sign_mode   <= ssp_pkg::SIGN_BIT15;
      cfg_q.timeout_ms  <= 10'd100;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/ssp_frame.sv @@
// Frame state machine of the servo status packet parser: header hunt,
// field capture, checksum, checks and value decoding. Depends on ssp_pkg.
`default_nettype none

module ssp_frame (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic          opcode_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire ssp_pkg::cfg_t cfg_i,
  output logic               res_valid_o,
  output ssp_pkg::res_t      res_o
);

  ssp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hunt_cnt_q, hunt_cnt_d;
  logic        last_ff_q, last_ff_d;
  logic [7:0]  frame_id_q, frame_id_d;
  logic [7:0]  frame_len_q, frame_len_d;
  logic [7:0]  frame_err_q, frame_err_d;
  logic [7:0]  param0_q, param0_d;
  logic [7:0]  param1_q, param1_d;
  logic [ssp_pkg::ParamIdxW-1:0] param_idx_q, param_idx_d;
  logic [7:0]  sum_q, sum_d;
  logic [9:0]  idle_q, idle_d;

  logic [1:0]  param_cnt;
  logic [10:0] idle_inc;
  logic [7:0]  sum_add;
  logic [3:0]  hunt_inc;
  logic        emit;
  ssp_pkg::res_t res;

  function automatic logic signed [ssp_pkg::ValueW-1:0] build_value(
    input logic [1:0] n, input logic [7:0] p0, input logic [7:0] p1,
    input logic order, input logic [1:0] mode);
    logic [15:0] w;
    logic [15:0] mag;
    logic        neg;
    begin
      if (n == 2'd1) begin
        w = {8'd0, p0};
      end else if (order) begin
        w = {p0, p1};
      end else begin
        w = {p1, p0};
      end
      neg = 1'b0;
      mag = w;
      if (mode == ssp_pkg::SIGN_BIT15 && w[15]) begin
        neg = 1'b1;
        mag = {1'b0, w[14:0]};
      end else if (mode == ssp_pkg::SIGN_BIT10 && w[10]) begin
        neg = 1'b1;
        mag = {w[15:11], 1'b0, w[9:0]};
      end
      if (n == 2'd0) begin
        build_value = '0;
      end else if (neg) begin
        build_value = -$signed({1'b0, mag});
      end else begin
        build_value = $signed({1'b0, mag});
      end
    end
  endfunction

  assign param_cnt = (cfg_i.param_len > 2'(ssp_pkg::MaxParamBytes)) ?
                     2'(ssp_pkg::MaxParamBytes) : cfg_i.param_len;
  assign idle_inc  = {1'b0, idle_q} + 11'd1;
  assign sum_add   = sum_q + rx_byte_i;
  assign hunt_inc  = hunt_cnt_q + 4'd1;

  always_comb begin
    phase_d     = phase_q;
    hunt_cnt_d  = hunt_cnt_q;
    last_ff_d   = last_ff_q;
    frame_id_d  = frame_id_q;
    frame_len_d = frame_len_q;
    frame_err_d = frame_err_q;
    param0_d    = param0_q;
    param1_d    = param1_q;
    param_idx_d = param_idx_q;
    sum_d       = sum_q;
    idle_d      = idle_q;
    emit        = 1'b0;
    res         = '0;

    if (opcode_i) begin
      if (!(phase_q == ssp_pkg::PH_HUNT && hunt_cnt_q == 4'd0 && !last_ff_q)) begin
        if (idle_inc > {1'b0, cfg_i.timeout_ms}) begin
          emit       = 1'b1;
          res.status = ssp_pkg::ST_TIMEOUT;
        end else begin
          idle_d = idle_inc[9:0];
        end
      end
    end else begin
      idle_d = '0;
      unique case (phase_q)
        ssp_pkg::PH_HUNT: begin
          if (last_ff_q && rx_byte_i == ssp_pkg::HeaderByte) begin
            phase_d    = ssp_pkg::PH_ID;
            hunt_cnt_d = '0;
            last_ff_d  = 1'b0;
          end else begin
            last_ff_d  = (rx_byte_i == ssp_pkg::HeaderByte);
            hunt_cnt_d = hunt_inc;
            if (hunt_inc > 4'(ssp_pkg::HuntLimit)) begin
              emit       = 1'b1;
              res.status = ssp_pkg::ST_NO_HEADER;
            end
          end
        end
        ssp_pkg::PH_ID: begin
          frame_id_d = rx_byte_i;
          sum_d      = rx_byte_i;
          phase_d    = ssp_pkg::PH_LEN;
        end
        ssp_pkg::PH_LEN: begin
          frame_len_d = rx_byte_i;
          sum_d       = sum_add;
          phase_d     = ssp_pkg::PH_ERR;
        end
        ssp_pkg::PH_ERR: begin
          frame_err_d = rx_byte_i;
          sum_d       = sum_add;
          param_idx_d = '0;
          phase_d     = (param_cnt == 2'd0) ? ssp_pkg::PH_SUM : ssp_pkg::PH_PARAM;
        end
        ssp_pkg::PH_PARAM: begin
          if (param_idx_q == 2'd0) begin
            param0_d = rx_byte_i;
          end else if (param_idx_q == 2'd1) begin
            param1_d = rx_byte_i;
          end
          sum_d       = sum_add;
          param_idx_d = param_idx_q + 2'd1;
          if (param_idx_d >= param_cnt) begin
            phase_d = ssp_pkg::PH_SUM;
          end
        end
        ssp_pkg::PH_SUM: begin
          emit       = 1'b1;
          res.src_id = frame_id_q;
          if (cfg_i.param_len == 2'd0 && cfg_i.expected_id != ssp_pkg::BroadcastId &&
              frame_id_q != cfg_i.expected_id) begin
            res.status = ssp_pkg::ST_ID_MISMATCH;
          end else if (cfg_i.param_len == 2'd0 && frame_len_q != ssp_pkg::StatusOnlyLen) begin
            res.status = ssp_pkg::ST_BAD_LENGTH;
          end else if (~sum_q != rx_byte_i) begin
            res.status = ssp_pkg::ST_CHECKSUM;
          end else begin
            res.status     = ssp_pkg::ST_OK;
            res.error_byte = frame_err_q;
            res.value      = build_value(param_cnt, param0_q, param1_q,
                                         cfg_i.byte_order, cfg_i.sign_mode);
          end
        end
        default: begin
          phase_d = ssp_pkg::PH_HUNT;
        end
      endcase
    end

    if (emit) begin
      phase_d     = ssp_pkg::PH_HUNT;
      hunt_cnt_d  = '0;
      last_ff_d   = 1'b0;
      frame_id_d  = '0;
      frame_len_d = '0;
      frame_err_d = '0;
      param0_d    = '0;
      param1_d    = '0;
      param_idx_d = '0;
      sum_d       = '0;
      idle_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ssp_pkg::PH_HUNT;
      hunt_cnt_q  <= '0;
      last_ff_q   <= 1'b0;
      frame_id_q  <= '0;
      frame_len_q <= '0;
      frame_err_q <= '0;
      param0_q    <= '0;
      param1_q    <= '0;
      param_idx_q <= '0;
      sum_q       <= '0;
      idle_q      <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      hunt_cnt_q  <= hunt_cnt_d;
      last_ff_q   <= last_ff_d;
      frame_id_q  <= frame_id_d;
      frame_len_q <= frame_len_d;
      frame_err_q <= frame_err_d;
      param0_q    <= param0_d;
      param1_q    <= param1_d;
      param_idx_q <= param_idx_d;
      sum_q       <= sum_d;
      idle_q      <= idle_d;
    end
  end

  assign res_valid_o = emit;
  assign res_o       = res;

endmodule

`default_nettype wire

@@ hw/rtl/servo_status_packet_parser.sv @@
// Servo status packet parser, top level: input word register, frame logic,
// result register and configuration registers. Depends on ssp_pkg.
// An accepted word is held in the input word register; a result that it
// completes goes to the result register. Throughput: one word per cycle,
// limited only by the result register when the master side stalls.
// Reset: rst_ni clears the input and result stages and returns the parser
// to header hunt with the configuration at its reset values.
`default_nettype none
`include "servo_status_packet_parser_assert.svh"

module servo_status_packet_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ssp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ssp_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // rx_byte[7:0]
  input  wire logic                         s_axis_tuser,  // opcode[0]
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // src_id[7:0], error_byte[15:8], value[32:16], zeros[39:33]
  output logic [ssp_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic [2:0]                        m_axis_tuser   // status[2:0]
);

  ssp_pkg::cfg_t cfg;
  ssp_pkg::res_t res;
  ssp_pkg::res_t out_q;
  logic          res_valid;
  logic          in_valid_q;
  logic          in_opcode_q;
  logic [7:0]    in_byte_q;
  logic          out_valid_q;
  logic          advance;
  logic          out_fail;
  logic          out_no_frame;

  ssp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_opcode_q <= s_axis_tuser;
      in_byte_q   <= s_axis_tdata;
    end
  end

  ssp_frame u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .opcode_i    (in_opcode_q),
    .rx_byte_i   (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'd0, out_q.value, out_q.error_byte, out_q.src_id};

  assign out_fail     = m_axis_tvalid && m_axis_tuser != ssp_pkg::ST_OK;
  assign out_no_frame = m_axis_tvalid && (m_axis_tuser == ssp_pkg::ST_NO_HEADER ||
                                          m_axis_tuser == ssp_pkg::ST_TIMEOUT);

  `SSP_ASSERT_NOW(a_status_range, m_axis_tvalid, m_axis_tuser <= ssp_pkg::ST_CHECKSUM)
  `SSP_ASSERT_NOW(a_fail_no_payload, out_fail, m_axis_tdata[32:8] == 25'd0)
  `SSP_ASSERT_NOW(a_no_id_without_frame, out_no_frame, m_axis_tdata[7:0] == 8'd0)
  `SSP_ASSERT_NEXT(a_result_loads, advance && res_valid, m_axis_tvalid)

endmodule

`default_nettype wire
